@@ rtl/assert_macros.svh @@
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, masked while reset is low
`define SPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked property, evaluated through reset too
`define SPE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/spe_pkg.sv @@
// shared types and codes of the shortest path engine
package spe_pkg;

    // transaction kinds carried on the input tuser
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_EDGE  = 2'd1;
    localparam logic [1:0] MODE_FIND  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_WALK_RD,
        ST_WALK_WB,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_NOTFOUND
    } t_state;

endpackage

@@ rtl/spe_edge_ram.sv @@
// edge weight ram, one write port and one registered read port
module spe_edge_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 13
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/shortest_path_engine_unit.sv @@
// shortest path engine top level: edge ram, dijkstra sequencer and result stream
//
// The block holds a MAX_NODES x MAX_NODES table of directed edge weights in one
// ram and answers path queries with array-based Dijkstra over nodes below
// node_count (ties go to the lowest index, relaxation only on strict gain).
// After reset, and for every clear transaction, a clearing pass writes all
// 2**(2*clog2(MAX_NODES)) edge entries, one per cycle, during which no
// transaction is accepted. A query runs at most an init step, then per visited
// node a min scan and a relax pass through the single read port of the edge and
// distance rams, one more scan at the end, a read and a write-back per path
// node for the backtrack and a read and a load per emitted result, plus any
// time the receiver stalls a result. One transaction is worked on at a time;
// the output register lets the next transaction in while the last result
// still waits.
`include "assert_macros.svh"

module shortest_path_engine_unit #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // node_count register
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    // query and edge transactions
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // from_node[3:0] to_node[7:4] edge_weight[19:8] edge_present[20]
    // source_node[24:21] target_node[28:25] zero[31:29]
    input  logic [31:0] s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]  s_axis_tuser,
    // path results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // path_node[3:0] path_distance[19:4] zero[23:20]
    output logic [23:0] m_axis_tdata,
    // found[0]
    output logic        m_axis_tuser,
    // last_step
    output logic        m_axis_tlast
);

    import spe_pkg::*;

    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int DW  = WEIGHT_BITS + NW;
    localparam int EW  = WEIGHT_BITS + 1;
    localparam int SW  = NW + DW;

    // input field split
    logic [3:0]  in_from, in_to, in_src, in_tgt;
    logic [11:0] in_weight;
    logic        in_present;
    assign in_from    = s_axis_tdata[3:0];
    assign in_to      = s_axis_tdata[7:4];
    assign in_weight  = s_axis_tdata[19:8];
    assign in_present = s_axis_tdata[20];
    assign in_src     = s_axis_tdata[24:21];
    assign in_tgt     = s_axis_tdata[28:25];

    t_state r_state, n_state;
    logic [4:0]           r_node_cnt;
    logic [NW-1:0]        r_last, n_last, r_src, n_src, r_tgt, n_tgt;
    logic [NW-1:0]        r_j, n_j, r_jq, n_jq, r_u, n_u, r_v, n_v;
    logic [NW-1:0]        r_cnt, n_cnt, r_k, n_k;
    logic                 r_pv, n_pv, r_issued, n_issued, r_have, n_have;
    logic [DW-1:0]        r_du, n_du;
    logic [MAX_NODES-1:0] r_reached, n_reached, r_visited, n_visited;
    logic [2*NW-1:0]      r_clr, n_clr;

    // memory port controls
    logic            edge_we;
    logic [2*NW-1:0] edge_waddr, edge_raddr;
    logic [EW-1:0]   edge_wdata, edge_q;
    logic            sc_we, st_we;
    logic [NW-1:0]   sc_waddr, sc_raddr, st_waddr, st_raddr;
    logic [SW-1:0]   sc_wdata, st_wdata;
    logic [SW-1:0]   r_sc_q, r_st_q;
    logic [SW-1:0]   r_scratch [2**NW];
    logic [SW-1:0]   r_stack [2**NW];

    // output register
    logic          r_ovalid, r_ofound, r_olast;
    logic [3:0]    r_onode;
    logic [15:0]   r_odist;
    logic          load_out, ld_found, ld_last;
    logic [3:0]    ld_node;
    logic [15:0]   ld_dist;
    logic          out_free;

    logic [NCW-1:0] nn;
    logic           cand;
    logic [NW-1:0]  cu;
    logic [DW-1:0]  cdu, dq, nd;
    logic           ch;
    logic [31:0]    dist_ext;

    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    spe_edge_ram #(
        .ADDR_BITS (2 * NW),
        .DATA_BITS (EW)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_q)
    );

    // distance and predecessor scratch ram
    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_scratch[sc_waddr] <= sc_wdata;
        end
        r_sc_q <= r_scratch[sc_raddr];
    end

    // path stack ram
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_stack[st_waddr] <= st_wdata;
        end
        r_st_q <= r_stack[st_raddr];
    end

    // node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt <= 5'd16;
        end else if (i_cfg_we) begin
            r_node_cnt <= i_cfg_wdata;
        end
    end

    // active node count, saturated to the table size
    always_comb begin
        if (int'(r_node_cnt) > MAX_NODES) begin
            nn = NCW'(MAX_NODES);
        end else begin
            nn = NCW'(r_node_cnt);
        end
    end

    assign dq = r_sc_q[DW-1:0];
    assign nd = r_du + DW'(edge_q[WEIGHT_BITS-1:0]);
    assign dist_ext = 32'(r_st_q[DW-1:0]);

    // sequencer next state and memory controls
    always_comb begin
        n_state   = r_state;
        n_last    = r_last;
        n_src     = r_src;
        n_tgt     = r_tgt;
        n_j       = r_j;
        n_jq      = r_jq;
        n_u       = r_u;
        n_v       = r_v;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_pv      = r_pv;
        n_issued  = r_issued;
        n_have    = r_have;
        n_du      = r_du;
        n_reached = r_reached;
        n_visited = r_visited;
        n_clr     = r_clr;
        edge_we    = 1'b0;
        edge_waddr = r_clr;
        edge_wdata = '0;
        edge_raddr = {r_u, r_j};
        sc_we      = 1'b0;
        sc_waddr   = r_jq;
        sc_wdata   = {r_u, nd};
        sc_raddr   = r_j;
        st_we      = 1'b0;
        st_waddr   = r_cnt;
        st_wdata   = {r_v, r_sc_q[DW-1:0]};
        st_raddr   = r_k;
        load_out   = 1'b0;
        ld_node    = 4'(r_st_q[SW-1:DW]);
        ld_dist    = (dist_ext > 32'hFFFF) ? 16'hFFFF : dist_ext[15:0];
        ld_found   = 1'b1;
        ld_last    = (r_k == '0);
        cand       = 1'b0;
        ch         = r_have;
        cu         = r_u;
        cdu        = r_du;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        MODE_CLEAR: begin
                            n_clr   = '0;
                            n_state = ST_CLEAR;
                        end
                        MODE_EDGE: begin
                            if (int'(in_from) < MAX_NODES && int'(in_to) < MAX_NODES) begin
                                edge_we    = 1'b1;
                                edge_waddr = {NW'(in_from), NW'(in_to)};
                                edge_wdata = in_present ?
                                             {1'b1, WEIGHT_BITS'(in_weight)} : '0;
                            end
                        end
                        MODE_FIND: begin
                            n_src  = NW'(in_src);
                            n_tgt  = NW'(in_tgt);
                            n_last = NW'(nn - NCW'(1));
                            if (NCW'(in_src) < nn && NCW'(in_tgt) < nn &&
                                int'(in_src) < MAX_NODES && int'(in_tgt) < MAX_NODES) begin
                                n_state = ST_INIT;
                            end else begin
                                n_state = ST_NOTFOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // clearing pass over the edge ram
            ST_CLEAR: begin
                edge_we = 1'b1;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = ST_IDLE;
                end
            end
            // source starts reached at distance zero
            ST_INIT: begin
                n_reached        = '0;
                n_reached[r_src] = 1'b1;
                n_visited        = '0;
                sc_we            = 1'b1;
                sc_waddr         = r_src;
                sc_wdata         = '0;
                n_j              = '0;
                n_pv             = 1'b0;
                n_issued         = 1'b0;
                n_have           = 1'b0;
                n_state          = ST_SCAN;
            end
            // pick the nearest reached, unvisited node
            ST_SCAN: begin
                if (!r_issued) begin
                    n_pv = 1'b1;
                    n_jq = r_j;
                    if (r_j == r_last) begin
                        n_issued = 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    cand = !r_visited[r_jq] && r_reached[r_jq] && (!r_have || dq < r_du);
                    if (cand) begin
                        ch  = 1'b1;
                        cu  = r_jq;
                        cdu = dq;
                    end
                    n_have = ch;
                    n_u    = cu;
                    n_du   = cdu;
                    if (r_jq == r_last) begin
                        n_j      = '0;
                        n_pv     = 1'b0;
                        n_issued = 1'b0;
                        if (ch) begin
                            n_visited[cu] = 1'b1;
                            n_state       = ST_RELAX;
                        end else if (r_reached[r_tgt]) begin
                            n_v     = r_tgt;
                            n_cnt   = '0;
                            n_state = ST_WALK_RD;
                        end else begin
                            n_state = ST_NOTFOUND;
                        end
                    end
                end
            end
            // relax the outgoing edges of the chosen node
            ST_RELAX: begin
                if (!r_issued) begin
                    n_pv = 1'b1;
                    n_jq = r_j;
                    if (r_j == r_last) begin
                        n_issued = 1'b1;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    if (edge_q[WEIGHT_BITS] && (!r_reached[r_jq] || nd < dq)) begin
                        sc_we             = 1'b1;
                        n_reached[r_jq]   = 1'b1;
                    end
                    if (r_jq == r_last) begin
                        n_j      = '0;
                        n_pv     = 1'b0;
                        n_issued = 1'b0;
                        n_have   = 1'b0;
                        n_state  = ST_SCAN;
                    end
                end
            end
            // backtrack from the target along predecessors
            ST_WALK_RD: begin
                sc_raddr = r_v;
                n_state  = ST_WALK_WB;
            end
            ST_WALK_WB: begin
                st_we = 1'b1;
                if (r_v == r_src || r_cnt == NW'(MAX_NODES - 1)) begin
                    n_k     = r_cnt;
                    n_state = ST_OUT_RD;
                end else begin
                    n_v     = r_sc_q[SW-1:DW];
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_WALK_RD;
                end
            end
            // emit the path source first
            ST_OUT_RD: begin
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_k == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k - 1'b1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            ST_NOTFOUND: begin
                if (out_free) begin
                    load_out = 1'b1;
                    ld_node  = '0;
                    ld_dist  = '0;
                    ld_found = 1'b0;
                    ld_last  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_pv      <= 1'b0;
            r_issued  <= 1'b0;
            r_have    <= 1'b0;
            r_reached <= '0;
            r_visited <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_pv      <= n_pv;
            r_issued  <= n_issued;
            r_have    <= n_have;
            r_reached <= n_reached;
            r_visited <= n_visited;
            r_j       <= n_j;
            r_k       <= n_k;
            r_cnt     <= n_cnt;
        end
    end

    // query payload registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_src  <= n_src;
        r_tgt  <= n_tgt;
        r_jq   <= n_jq;
        r_u    <= n_u;
        r_du   <= n_du;
        r_v    <= n_v;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_onode  <= ld_node;
            r_odist  <= ld_dist;
            r_ofound <= ld_found;
            r_olast  <= ld_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_odist, r_onode};
    assign m_axis_tuser  = r_ofound;
    assign m_axis_tlast  = r_olast;

    // checks
    `SPE_ASSERT_ALWAYS(a_rst_clear, $past(!i_rst_n) |-> r_state == ST_CLEAR, "no clear after reset")
    `SPE_ASSERT(a_relax_visited, r_state == ST_RELAX |-> r_visited[r_u], "relax of unvisited node")
    `SPE_ASSERT(a_notfound_last, r_ovalid && !r_ofound |-> r_olast, "unreachable result not last")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the shortest path engine unit
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import spe_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 700;

    typedef struct packed {
        logic [3:0]  node;
        logic [15:0] path_dist;
        logic        found;
        logic        last;
    } t_path_step;

    typedef struct {
        logic [1:0] mode;
        logic [3:0] from_n;
        logic [3:0] to_n;
        logic [11:0] weight;
        logic       present;
        logic [3:0] src;
        logic [3:0] tgt;
        bit         typed;
        t_path_step step;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    // predictor state
    logic [12:0] edge_weights [0:255];
    logic [4:0]  node_cnt;
    t_path_step  expected_steps [$];

    int errors = 0;
    int cycles = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;
    int steps_seen = 0;
    int queries_sent = 0;

    shortest_path_engine_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("shortest_path_engine_unit regression: fail");
            $finish;
        end
    end

    // dijkstra over the active nodes, pushes the expected path steps
    task automatic find_path(input logic [3:0] src, input logic [3:0] tgt);
        int n;
        int dist_tab [16];
        bit reach [16];
        bit vis [16];
        bit pv [16];
        int pred [16];
        int stack_nodes [16];
        int cnt;
        int u;
        int v;
        int nd;
        bit have;
        t_path_step st;
        n = (node_cnt > 16) ? 16 : node_cnt;
        if (src >= n || tgt >= n) begin
            st = '{node: 4'd0, path_dist: 16'd0, found: 1'b0, last: 1'b1};
            expected_steps.push_back(st);
            return;
        end
        for (int i = 0; i < 16; i++) begin
            dist_tab[i] = 0; reach[i] = 0; vis[i] = 0; pv[i] = 0; pred[i] = 0;
        end
        reach[src] = 1;
        for (int i = 0; i < n; i++) begin
            have = 0;
            u = 0;
            for (int j = 0; j < n; j++) begin
                if (!vis[j] && reach[j] && (!have || dist_tab[j] < dist_tab[u])) begin
                    u = j;
                    have = 1;
                end
            end
            if (!have) break;
            vis[u] = 1;
            for (int k = 0; k < n; k++) begin
                if (edge_weights[u * 16 + k][12]) begin
                    nd = dist_tab[u] + 32'(edge_weights[u * 16 + k][11:0]);
                    if (!reach[k] || nd < dist_tab[k]) begin
                        dist_tab[k] = nd; reach[k] = 1; pv[k] = 1; pred[k] = u;
                    end
                end
            end
        end
        if (!reach[tgt]) begin
            st = '{node: 4'd0, path_dist: 16'd0, found: 1'b0, last: 1'b1};
            expected_steps.push_back(st);
            return;
        end
        cnt = 0;
        v = tgt;
        while (cnt < 16) begin
            stack_nodes[cnt] = v;
            cnt = cnt + 1;
            if (v == src || !pv[v]) break;
            v = pred[v];
        end
        for (int k = 0; k < cnt; k++) begin
            v = stack_nodes[cnt - 1 - k];
            st.node = v[3:0];
            st.path_dist = (dist_tab[v] > 65535) ? 16'hffff : dist_tab[v][15:0];
            st.found = 1'b1;
            st.last = (k == cnt - 1);
            expected_steps.push_back(st);
        end
    endtask

    // apply one accepted transaction to the predictor
    task automatic predict_item(input t_stim_row r);
        case (r.mode)
            MODE_CLEAR: begin
                for (int i = 0; i < 256; i++) edge_weights[i] = '0;
            end
            MODE_EDGE: begin
                edge_weights[{r.from_n, r.to_n}] = r.present ? {1'b1, r.weight} : 13'd0;
            end
            MODE_FIND: begin
                queries_sent++;
                if (r.typed) expected_steps.push_back(r.step);
                else find_path(r.src, r.tgt);
            end
            default: ;
        endcase
    endtask

    // offer one transaction and wait for the handshake
    task automatic send_item(input t_stim_row r);
        while ($urandom_range(99) < sender_idle_pct) @(negedge i_clk);
        s_axis_tdata = {3'b000, r.tgt, r.src, r.present, r.weight, r.to_n, r.from_n};
        s_axis_tuser = r.mode;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(r);
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait until every expected step has arrived and the block is quiet
    task automatic drain();
        while (expected_steps.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_node_count(input logic [4:0] val);
        i_cfg_wdata = val;
        i_cfg_we = 1'b1;
        node_cnt = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_stim_row make_row(input logic [1:0] md, input int f, input int t,
                                           input int w, input bit p, input int s,
                                           input int g);
        t_stim_row r;
        r.mode = md; r.from_n = 4'(f); r.to_n = 4'(t); r.weight = 12'(w); r.present = p;
        r.src = 4'(s); r.tgt = 4'(g); r.typed = 0; r.step = '0;
        return r;
    endfunction

    function automatic t_stim_row typed_row(input t_stim_row r, input int nd, input int ds,
                                            input bit fd);
        r.typed = 1;
        r.step = '{node: 4'(nd), path_dist: 16'(ds), found: fd, last: 1'b1};
        return r;
    endfunction

    // random transaction biased toward the active nodes
    function automatic t_stim_row random_row();
        t_stim_row r;
        int n;
        int pick;
        n = (node_cnt > 16) ? 16 : ((node_cnt == 0) ? 1 : node_cnt);
        r = make_row(MODE_EDGE, $urandom_range(15), $urandom_range(15), $urandom_range(4095),
                     1'($urandom_range(1)), $urandom_range(15), $urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 2) r.mode = MODE_CLEAR;
        else if (pick < 4) r.mode = MODE_SPARE;
        else if (pick < 34) r.mode = MODE_FIND;
        if ($urandom_range(9) != 0) begin
            r.from_n = 4'($urandom_range(n - 1)); r.to_n = 4'($urandom_range(n - 1));
            r.src = 4'($urandom_range(n - 1)); r.tgt = 4'($urandom_range(n - 1));
        end
        pick = $urandom_range(9);
        if (pick < 5) r.weight = 12'($urandom_range(15));
        else if (pick == 5) r.weight = 12'hfff;
        else if (pick == 6) r.weight = 12'h000;
        if (r.mode == MODE_EDGE && $urandom_range(5) != 0) r.present = 1'b1;
        return r;
    endfunction

    // receiver back-pressure, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready = 1'b0;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_path_step exp_s;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            steps_seen++;
            if (expected_steps.size() == 0) begin
                $error("unexpected result transaction data=%h", m_axis_tdata);
                errors++;
            end else begin
                exp_s = expected_steps.pop_front();
                if (m_axis_tdata[3:0] !== exp_s.node) begin
                    $error("path_node expected %0d actual %0d", exp_s.node, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[19:4] !== exp_s.path_dist) begin
                    $error("path_distance expected %0d actual %0d", exp_s.path_dist,
                           m_axis_tdata[19:4]);
                    errors++;
                end
                if (m_axis_tuser !== exp_s.found) begin
                    $error("found expected %0d actual %0d", exp_s.found, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tlast !== exp_s.last) begin
                    $error("last_step expected %0d actual %0d", exp_s.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // main sequence
    initial begin
        t_stim_row dir_rows [$];
        logic [4:0] count_plan [10];
        int phase_pct [4][2];
        node_cnt = 5'd16;
        for (int i = 0; i < 256; i++) edge_weights[i] = '0;
        count_plan = '{5'd16, 5'd2, 5'd31, 5'd5, 5'd1, 5'd0, 5'd9, 5'd17, 5'd3, 5'd16};
        phase_pct = '{'{0, 0}, '{86, 0}, '{0, 86}, '{8, 8}};

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        // clearing pass after reset, then program the register
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_node_count(5'd16);

        // directed: empty graph, self path, extreme weights, removal, spare mode, clear
        dir_rows.push_back(typed_row(make_row(MODE_FIND, 0, 0, 0, 0, 0, 15), 0, 0, 0));
        dir_rows.push_back(typed_row(make_row(MODE_FIND, 0, 0, 0, 0, 7, 7), 7, 0, 1));
        dir_rows.push_back(make_row(MODE_EDGE, 0, 1, 4095, 1, 0, 0));
        dir_rows.push_back(make_row(MODE_EDGE, 1, 2, 0, 1, 0, 0));
        dir_rows.push_back(make_row(MODE_EDGE, 0, 2, 4095, 1, 0, 0));
        dir_rows.push_back(make_row(MODE_EDGE, 2, 15, 1234, 1, 0, 0));
        dir_rows.push_back(make_row(MODE_EDGE, 15, 15, 1, 1, 0, 0));
        dir_rows.push_back(make_row(MODE_EDGE, 15, 0, 4095, 1, 0, 0));
        dir_rows.push_back(make_row(MODE_FIND, 0, 0, 0, 0, 0, 15));
        dir_rows.push_back(make_row(MODE_FIND, 0, 0, 0, 0, 15, 2));
        dir_rows.push_back(make_row(MODE_EDGE, 1, 2, 4095, 0, 0, 0));
        dir_rows.push_back(make_row(MODE_FIND, 0, 0, 0, 0, 0, 15));
        dir_rows.push_back(make_row(MODE_SPARE, 15, 15, 4095, 1, 15, 15));
        dir_rows.push_back(make_row(MODE_EDGE, 3, 4, 4095, 1, 15, 15));
        dir_rows.push_back(make_row(MODE_FIND, 0, 0, 0, 0, 3, 4));
        dir_rows.push_back(make_row(MODE_FIND, 0, 0, 0, 0, 4, 3));
        dir_rows.push_back(make_row(MODE_CLEAR, 15, 15, 4095, 1, 15, 15));
        dir_rows.push_back(typed_row(make_row(MODE_FIND, 0, 0, 0, 0, 0, 1), 0, 0, 0));
        dir_rows.push_back(typed_row(make_row(MODE_FIND, 0, 0, 0, 0, 15, 0), 0, 0, 0));
        foreach (dir_rows[i]) send_item(dir_rows[i]);
        drain();

        // random phases across register settings and idling patterns
        for (int ph = 0; ph < 10; ph++) begin
            write_node_count(count_plan[ph]);
            sender_idle_pct = phase_pct[ph % 4][0];
            recv_stall_pct = phase_pct[ph % 4][1];
            // long receiver hold-off while the sender keeps offering
            if (ph == 3 || ph == 9) hold_left = 4000;
            for (int k = 0; k < 40; k++) send_item(random_row());
            drain();
        end

        $display("covered %0d transactions, %0d queries, %0d path steps checked",
                 items_sent, queries_sent, steps_seen);
        $display("node counts 0 to 31, edge weights 0 to 4095, idle and stall phases");
        if (errors == 0 && expected_steps.size() == 0) begin
            $display("shortest_path_engine_unit regression: pass");
        end else begin
            $display("shortest_path_engine_unit regression: fail");
        end
        $finish;
    end

endmodule
